@@ design/tvfi_pkg.sv @@
// ----------------------------------------------------------------------------
// tvfi_pkg
// Shared widths, codes and types of the tidal volume flow integrator.
// ----------------------------------------------------------------------------
package tvfi_pkg;

   localparam int ACC_BITS       = 48;
   localparam int RAW_BITS       = 16;
   localparam int FLOW_BITS      = 16;
   localparam int MAG_BITS       = 16;
   localparam int TIME_BITS      = 32;
   localparam int THRESH_BITS    = 15;
   localparam int VOLUME_BITS    = 48;
   localparam int PROD_BITS      = MAG_BITS + TIME_BITS;
   localparam int SUM_BITS       = ((ACC_BITS > PROD_BITS) ? ACC_BITS : PROD_BITS) + 1;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET  = THRESH_BITS'(60);
   localparam logic [TIME_BITS-1:0]   TIMEOUT_RESET = TIME_BITS'(10000);

   // raw words that read as an invalid flow
   localparam logic [RAW_BITS-1:0] BAD_RAW_LO    = RAW_BITS'(8);
   localparam logic [RAW_BITS-1:0] BAD_RAW_HI    = RAW_BITS'(127);
   localparam logic [RAW_BITS-1:0] BAD_RAW_EXACT = RAW_BITS'(39686);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_READ_FAIL = 2'd1,
      STATUS_INVALID   = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FLOW_THRESHOLD = 1'b0,
      CSR_IDLE_TIMEOUT   = 1'b1
   } csr_index_type;

endpackage

@@ design/tidal_volume_flow_integrator.sv @@
// ----------------------------------------------------------------------------
// tidal_volume_flow_integrator
// Integrates sensor flow over time into a saturating tidal volume.
// ----------------------------------------------------------------------------
// One item per cycle while the output is not stalled. An accepted item sits in
// an input register; when the output stage is free, a single 16 x 32 multiply
// and a 49-bit add or subtract update the volume accumulator and the result
// register together, so the following item already sees the new volume. A
// stalled result holds the input register, and the block keeps taking items as
// long as one of the two stages is free.
module tidal_volume_flow_integrator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [tvfi_pkg::RAW_BITS-1:0]          req_raw_sample,
   input  logic                                   req_read_ok,
   input  logic [tvfi_pkg::TIME_BITS-1:0]         req_now_ms,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [tvfi_pkg::FLOW_BITS-1:0]  rsp_flow_counts,
   output logic [tvfi_pkg::VOLUME_BITS-1:0]       rsp_volume,
   output tvfi_pkg::status_type                   rsp_status,
   output logic                                   rsp_active,
   input  logic                                   csr_write_enable,
   input  logic [tvfi_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tvfi_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);
   import tvfi_pkg::*;

   logic                         in_valid_ff;
   logic [RAW_BITS-1:0]          raw_ff;
   logic                         read_ok_ff;
   logic [TIME_BITS-1:0]         now_ff;

   logic                         out_valid_ff;
   logic signed [FLOW_BITS-1:0]  flow_ff;
   logic [VOLUME_BITS-1:0]       volume_ff;
   status_type                   status_ff;
   logic                         active_ff;

   logic [ACC_BITS-1:0]          volume_acc_ff;
   logic [ACC_BITS-1:0]          volume_acc_in;
   logic [TIME_BITS-1:0]         last_active_ff;
   logic [TIME_BITS-1:0]         last_active_in;
   logic [THRESH_BITS-1:0]       threshold_ff;
   logic [TIME_BITS-1:0]         timeout_ff;

   logic                         out_free;
   logic                         advance;

   logic signed [FLOW_BITS-1:0]  flow;
   logic signed [FLOW_BITS:0]    flow_wide;
   logic [MAG_BITS-1:0]          mag;
   logic [TIME_BITS-1:0]         dt;
   logic [PROD_BITS-1:0]         delta;
   logic [SUM_BITS-1:0]          acc_ext;
   logic [SUM_BITS-1:0]          delta_ext;
   logic [SUM_BITS-1:0]          sum_ext;
   logic [SUM_BITS-1:0]          acc_max_ext;
   logic [SUM_BITS-1:0]          vol_max_ext;
   logic [SUM_BITS-1:0]          acc_next_ext;
   logic                         bad_reading;

   logic signed [FLOW_BITS-1:0]  flow_in;
   logic [VOLUME_BITS-1:0]       volume_in;
   status_type                   status_in;
   logic                         active_in;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign rsp_valid       = out_valid_ff;
   assign rsp_flow_counts = flow_ff;
   assign rsp_volume      = volume_ff;
   assign rsp_status      = status_ff;
   assign rsp_active      = active_ff;

   // raw minus the offset is the raw word with its top bit flipped
   assign flow        = signed'({~raw_ff[RAW_BITS-1], raw_ff[RAW_BITS-2:0]});
   assign flow_wide   = {flow[FLOW_BITS-1], flow};
   assign mag         = flow[FLOW_BITS-1] ? MAG_BITS'(-flow_wide) : MAG_BITS'(flow_wide);
   assign dt          = now_ff - last_active_ff;
   assign delta       = PROD_BITS'(mag) * PROD_BITS'(dt);
   assign acc_ext     = SUM_BITS'(volume_acc_ff);
   assign delta_ext   = SUM_BITS'(delta);
   assign sum_ext     = flow[FLOW_BITS-1] ? (acc_ext - delta_ext) : (acc_ext + delta_ext);
   assign acc_max_ext = {{(SUM_BITS-ACC_BITS){1'b0}}, {ACC_BITS{1'b1}}};
   assign vol_max_ext = {{(SUM_BITS-VOLUME_BITS){1'b0}}, {VOLUME_BITS{1'b1}}};
   assign bad_reading = (raw_ff >= BAD_RAW_LO && raw_ff <= BAD_RAW_HI)
                        || raw_ff == BAD_RAW_EXACT;

   always_comb begin
      acc_next_ext   = acc_ext;
      last_active_in = last_active_ff;
      flow_in        = flow;
      status_in      = STATUS_OK;
      active_in      = 1'b0;
      if (!read_ok_ff) begin
         acc_next_ext = '0;
         flow_in      = '0;
         status_in    = STATUS_READ_FAIL;
      end else if (bad_reading) begin
         acc_next_ext = '0;
         status_in    = STATUS_INVALID;
      end else if (SUM_BITS'(mag) > SUM_BITS'(threshold_ff)) begin
         active_in      = 1'b1;
         last_active_in = now_ff;
         if (flow[FLOW_BITS-1]) begin
            acc_next_ext = (delta_ext > acc_ext) ? '0 : sum_ext;
         end else begin
            acc_next_ext = (sum_ext > acc_max_ext) ? acc_max_ext : sum_ext;
         end
      end else if (dt > timeout_ff) begin
         acc_next_ext = '0;
      end
      volume_acc_in = acc_next_ext[ACC_BITS-1:0];
      volume_in     = (acc_next_ext > vol_max_ext) ? {VOLUME_BITS{1'b1}}
                                                   : acc_next_ext[VOLUME_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         timeout_ff   <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FLOW_THRESHOLD: threshold_ff <= csr_write_data[THRESH_BITS-1:0];
            CSR_IDLE_TIMEOUT:   timeout_ff   <= csr_write_data[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         raw_ff     <= req_raw_sample;
         read_ok_ff <= req_read_ok;
         now_ff     <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         volume_acc_ff  <= '0;
         last_active_ff <= '0;
      end else begin
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            volume_acc_ff  <= volume_acc_in;
            last_active_ff <= last_active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flow_ff   <= flow_in;
         volume_ff <= volume_in;
         status_ff <= status_in;
         active_ff <= active_in;
      end
   end

endmodule

@@ design/tvfi_checker.sv @@
// ----------------------------------------------------------------------------
// tvfi_checker
// Port-level checks of the tidal volume flow integrator, bound to the top.
// ----------------------------------------------------------------------------
module tvfi_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic [tvfi_pkg::RAW_BITS-1:0]          req_raw_sample,
   input logic                                   req_read_ok,
   input logic [tvfi_pkg::TIME_BITS-1:0]         req_now_ms,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [tvfi_pkg::FLOW_BITS-1:0]  rsp_flow_counts,
   input logic [tvfi_pkg::VOLUME_BITS-1:0]       rsp_volume,
   input logic [1:0]                             rsp_status,
   input logic                                   rsp_active,
   input logic                                   csr_write_enable,
   input logic [tvfi_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input logic [tvfi_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);
   import tvfi_pkg::*;

   logic unused_inputs;
   assign unused_inputs = ^{req_valid, req_ready, req_raw_sample, req_read_ok, req_now_ms,
                            csr_write_enable, csr_index, csr_write_data};

   // errors clear the volume and never integrate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_volume == '0 && !rsp_active)
      else $error("error item with volume or active set");

   // failed read reports zero flow
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_READ_FAIL |-> rsp_flow_counts == '0)
      else $error("read failure with nonzero flow");

   // integration needs a flow above the dead band
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_active |-> rsp_flow_counts != '0)
      else $error("active item with zero flow");

   // a stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_volume)
                                  && $stable(rsp_flow_counts))
      else $error("stalled item changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("item valid after reset");

endmodule

bind tidal_volume_flow_integrator tvfi_checker u_tvfi_checker (.*);
